/* hdl/double_hash_open_address_table_unit_macros.svh */
// Assertion helpers for the table unit RTL
`ifndef DOUBLE_HASH_OPEN_ADDRESS_TABLE_UNIT_MACROS_SVH
`define DOUBLE_HASH_OPEN_ADDRESS_TABLE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DH_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define DH_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* hdl/dhot_pkg.sv */
package dhot_pkg;

  localparam logic [31:0] MURMUR_MULT   = 32'h5bd1e995;
  localparam logic [31:0] SEED_AT_RESET = 32'h12345678;
  localparam logic [10:0] SIZE_AT_RESET = 11'd1024;
  localparam logic [31:0] POLY_START    = 32'd7;
  localparam int          CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_SIZE = 2'd0,
    CFG_HASH_SEED  = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_state_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_MIX, S_M1S, S_M1W, S_M2S, S_M2W, S_PRD, S_PEV, S_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [15:0] entry_handle;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [15:0] found_handle;
    logic [10:0] probe_count;
  } out_t;

endpackage

/* hdl/dhot_ram.sv */
module dhot_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/dhot_div.sv */
module dhot_div #(
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] remainder
);

  logic [31:0]   dvd_r;
  logic [DW-1:0] dsr_r;
  logic [DW-1:0] rem_r;
  logic [4:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // one restoring step per cycle
  assign trial = {rem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // flag the cycle after the last step
      done_r <= !start && busy_r && (cnt_r == 5'd0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[30:0], 1'b0};
        rem_r <= (trial >= {1'b0, dsr_r}) ? diff[DW-1:0] : trial[DW-1:0];
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* hdl/double_hash_open_address_table_unit.sv */
// Sequence: a non-final key byte passes the hash states MUL and MIX with busy high
// and returns to idle. A final byte hashes, runs two modulo passes on the shared
// divider, then one read and one evaluate state per probe, then a result state that
// strobes; a full table on insert skips probing, a too-long key strobes after hashing.
// Throughput: the next beat is taken in the idle state after the strobe.
// Reset: a clearing pass writes every slot of the slot memory empty, with busy high.
`include "double_hash_open_address_table_unit_macros.svh"

module double_hash_open_address_table_unit #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int MAX_KEY_BYTES = 32,
  parameter int HANDLE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  dhot_pkg::in_t                 in_item,
  output logic                          out_valid,
  output dhot_pkg::out_t                out_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dhot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SW  = $clog2(TABLE_DEPTH + 1);
  localparam int SW2 = (SW > 11) ? SW : 11;
  localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
  localparam int IW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KW  = 8 * MAX_KEY_BYTES;
  localparam int WW  = 2 + LW + HANDLE_BITS + KW;

  dhot_pkg::fsm_t state_r, state_nxt;
  logic [AW-1:0]          clr_r;
  logic [10:0]            size_r;
  logic [31:0]            seed_r;
  logic [31:0]            mur_r, poly_r;
  dhot_pkg::in_t          item_r;
  logic [7:0]             buf_r [MAX_KEY_BYTES];
  logic [LW-1:0]          len_r;
  logic                   ovf_r;
  logic [SW-1:0]          pos_r, step_r, prb_r;
  logic [SW2-1:0]         occ_r;
  dhot_pkg::out_t         res_r;

  logic [SW2-1:0]         ts_ext, s_ext;
  logic [SW-1:0]          s;
  logic [KW-1:0]          key_m;
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [WW-1:0]          wdata, rdata;
  logic                   div_start, div_done;
  logic [31:0]            div_dvd;
  logic [SW-1:0]          div_dsr, div_rem;
  dhot_pkg::slot_state_t  rd_st;
  logic                   key_eq, is_ins, is_rem, take, stop_empty, exhausted, occ_ok;
  logic [SW:0]            pos_sum;
  logic [SW-1:0]          pos_adv;
  logic [31:0]            mul_lo;
  logic                   fresh;

  // clamp the table size into the legal range
  assign ts_ext = SW2'(size_r);
  always_comb begin
    if (ts_ext < SW2'(3)) s_ext = SW2'(3);
    else if (ts_ext > SW2'(TABLE_DEPTH)) s_ext = SW2'(TABLE_DEPTH);
    else s_ext = ts_ext;
  end
  assign s = s_ext[SW-1:0];

  // key bytes past the key length read as zero
  always_comb begin
    for (int k = 0; k < MAX_KEY_BYTES; k++) begin
      key_m[8*k +: 8] = (LW'(k) < len_r) ? buf_r[k] : 8'h00;
    end
  end

  // probe evaluation
  assign rd_st      = dhot_pkg::slot_state_t'(rdata[WW-1 -: 2]);
  assign key_eq     = (rdata[WW-3 -: LW] == len_r) && (rdata[KW-1:0] == key_m);
  assign is_ins     = item_r.mode == dhot_pkg::MODE_INSERT;
  assign is_rem     = item_r.mode == dhot_pkg::MODE_REMOVE;
  assign take       = is_ins ? (rd_st != dhot_pkg::SLOT_USED)
                             : ((rd_st == dhot_pkg::SLOT_USED) && key_eq);
  assign stop_empty = !is_ins && (rd_st == dhot_pkg::SLOT_EMPTY);
  assign exhausted  = prb_r == s;
  assign occ_ok     = ({1'b0, occ_r} + (SW2+1)'(1)) < (SW2+1)'(s);
  assign pos_sum    = {1'b0, pos_r} + {1'b0, step_r};
  assign pos_adv    = (pos_sum >= {1'b0, s}) ? SW'(pos_sum - {1'b0, s}) : pos_sum[SW-1:0];
  assign mul_lo     = (mur_r ^ {24'h0, item_r.key_byte}) * dhot_pkg::MURMUR_MULT;
  assign fresh      = (len_r == '0) && !ovf_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dhot_pkg::S_CLEAR: if (clr_r == AW'(TABLE_DEPTH - 1)) state_nxt = dhot_pkg::S_IDLE;
      dhot_pkg::S_IDLE:  if (start) state_nxt = dhot_pkg::S_MUL;
      dhot_pkg::S_MUL:   state_nxt = dhot_pkg::S_MIX;
      dhot_pkg::S_MIX: begin
        if (!item_r.key_last) state_nxt = dhot_pkg::S_IDLE;
        else if (ovf_r) state_nxt = dhot_pkg::S_DONE;
        else state_nxt = dhot_pkg::S_M1S;
      end
      dhot_pkg::S_M1S:   state_nxt = dhot_pkg::S_M1W;
      dhot_pkg::S_M1W:   if (div_done) state_nxt = dhot_pkg::S_M2S;
      dhot_pkg::S_M2S:   state_nxt = dhot_pkg::S_M2W;
      dhot_pkg::S_M2W: begin
        if (div_done) state_nxt = (is_ins && !occ_ok) ? dhot_pkg::S_DONE : dhot_pkg::S_PRD;
      end
      dhot_pkg::S_PRD:   state_nxt = dhot_pkg::S_PEV;
      dhot_pkg::S_PEV: begin
        state_nxt = (take || stop_empty || exhausted) ? dhot_pkg::S_DONE : dhot_pkg::S_PRD;
      end
      dhot_pkg::S_DONE:  state_nxt = dhot_pkg::S_IDLE;
      default:           state_nxt = dhot_pkg::S_IDLE;
    endcase
  end

  // outputs and memory / divider controls
  always_comb begin
    we        = 1'b0;
    waddr     = pos_r[AW-1:0];
    wdata     = {dhot_pkg::SLOT_EMPTY, {(WW-2){1'b0}}};
    div_start = 1'b0;
    div_dvd   = mur_r;
    div_dsr   = s;
    case (state_r)
      dhot_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
      end
      dhot_pkg::S_M1S: div_start = 1'b1;
      dhot_pkg::S_M2S: begin
        div_start = 1'b1;
        div_dvd   = poly_r;
        div_dsr   = s - SW'(2);
      end
      dhot_pkg::S_PEV: begin
        if (take && is_ins) begin
          we    = 1'b1;
          wdata = {dhot_pkg::SLOT_USED, len_r, HANDLE_BITS'(item_r.entry_handle), key_m};
        end else if (take && is_rem) begin
          we    = 1'b1;
          wdata = {dhot_pkg::SLOT_DELETED, rdata[WW-3:0]};
        end
      end
      default: ;
    endcase
  end

  assign raddr      = pos_r[AW-1:0];
  assign busy       = state_r != dhot_pkg::S_IDLE;
  assign out_valid  = state_r == dhot_pkg::S_DONE;
  assign out_result = res_r;
  assign cfg_ready  = 1'b1;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dhot_pkg::S_CLEAR;
      clr_r   <= '0;
      size_r  <= dhot_pkg::SIZE_AT_RESET;
      seed_r  <= dhot_pkg::SEED_AT_RESET;
      mur_r   <= dhot_pkg::SEED_AT_RESET;
      poly_r  <= dhot_pkg::POLY_START;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dhot_pkg::CFG_TABLE_SIZE) size_r <= cfg_data[10:0];
        else if (cfg_index == dhot_pkg::CFG_HASH_SEED) seed_r <= cfg_data;
      end
      case (state_r)
        dhot_pkg::S_CLEAR: clr_r <= clr_r + AW'(1);
        dhot_pkg::S_IDLE: begin
          if (start) begin
            mur_r  <= fresh ? seed_r : mur_r;
            poly_r <= fresh ? dhot_pkg::POLY_START : poly_r;
            if (len_r < LW'(MAX_KEY_BYTES)) len_r <= len_r + LW'(1);
            else ovf_r <= 1'b1;
          end
        end
        dhot_pkg::S_MUL: begin
          mur_r  <= mul_lo;
          poly_r <= (poly_r << 5) - poly_r + {24'h0, item_r.key_byte};
        end
        dhot_pkg::S_MIX: mur_r <= mur_r ^ (mur_r >> 15);
        dhot_pkg::S_PEV: begin
          if (take && is_ins && occ_r != '1) occ_r <= occ_r + SW2'(1);
          else if (take && is_rem && occ_r != '0) occ_r <= occ_r - SW2'(1);
        end
        dhot_pkg::S_DONE: begin
          len_r <= '0;
          ovf_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload: item, key buffer, probe walk, result
  always_ff @(posedge clk) begin
    case (state_r)
      dhot_pkg::S_IDLE: begin
        if (start) begin
          item_r <= in_item;
          if (len_r < LW'(MAX_KEY_BYTES)) buf_r[len_r[IW-1:0]] <= in_item.key_byte;
        end
      end
      dhot_pkg::S_MIX: begin
        prb_r <= '0;
        res_r <= '{status: dhot_pkg::ST_TOO_LONG, default: '0};
      end
      dhot_pkg::S_M1W: if (div_done) pos_r <= div_rem;
      dhot_pkg::S_M2W: begin
        if (div_done) step_r <= div_rem + SW'(1);
        res_r <= '{status: dhot_pkg::ST_FULL, default: '0};
      end
      dhot_pkg::S_PRD: prb_r <= prb_r + SW'(1);
      dhot_pkg::S_PEV: begin
        res_r.probe_count  <= 11'(prb_r);
        res_r.slot_index   <= take ? 10'(pos_r) : 10'd0;
        res_r.found_handle <= (take && !is_ins && !is_rem) ?
                              16'(rdata[KW +: HANDLE_BITS]) : 16'd0;
        if (take) begin
          if (is_ins) res_r.status <= dhot_pkg::ST_INSERTED;
          else if (is_rem) res_r.status <= dhot_pkg::ST_REMOVED;
          else res_r.status <= dhot_pkg::ST_FOUND;
        end else begin
          res_r.status <= is_ins ? dhot_pkg::ST_FULL : dhot_pkg::ST_NOT_FOUND;
          pos_r        <= pos_adv;
        end
      end
      default: ;
    endcase
  end

  dhot_div #(.DW(SW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .remainder (div_rem)
  );

  dhot_ram #(.W(WW), .D(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  `DH_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_valid, busy)
  `DH_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `DH_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `DH_ASSERT_IMP(a_write_probe, clk, rst_n, we && state_r != dhot_pkg::S_CLEAR, take)

endmodule
